// File: design/arwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwt_pkg
// Shared constants, codes and types of the audio ring writer with trim loop
// ----------------------------------------------------------------------------
package arwt_pkg;

    localparam int RingSamples = 512;
    localparam int AddrW       = $clog2(RingSamples);
    localparam int SampleW     = 16;
    localparam int DmaW        = 10;
    localparam int TrimW       = 6;
    localparam int HoldW       = 8;
    localparam int GainW       = 10;
    localparam int LimitW      = 20;
    localparam int CenterW     = 6;
    localparam int ErrW        = AddrW + 1;
    localparam int IntegW      = LimitW + 1;
    localparam int PropProdW   = GainW + 1 + ErrW;
    localparam int NumW        = 32;
    localparam int KindW       = 2;

    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = LimitW;

    localparam int InDataW     = 32;
    localparam int OutDataW    = 32;

    localparam int MaxResults  = 3;
    localparam int FifoDepth   = 16;
    localparam int FifoPtrW    = $clog2(FifoDepth);
    localparam int FifoCntW    = FifoPtrW + 1;

    localparam logic [AddrW-1:0]  HalfRing   = AddrW'(RingSamples / 2);
    localparam logic [DmaW-1:0]   RingSize   = DmaW'(RingSamples);
    localparam logic [15:0]       Milli      = 16'd1000;
    localparam logic [NumW-1:0]   TrimSatNum = NumW'(64000);
    localparam logic [TrimW-1:0]  TrimMax    = TrimW'(63);
    // floor(n / 1000) == (n * Recip1000) >> RecipShift for n < 64000
    localparam int                RecipShift = 26;
    localparam logic [16:0]       Recip1000  = 17'd67109;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [KindW-1:0] {
        KIND_WRITE = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_TRIM  = 2'd2
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_AUDIO_ENABLE = 3'd0,
        CFG_TRIM_CENTER  = 3'd1,
        CFG_PROP_GAIN    = 3'd2,
        CFG_INTEG_GAIN   = 3'd3,
        CFG_INTEG_LIMIT  = 3'd4,
        CFG_HOLD_PACKETS = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        t_kind              kind;
        logic [AddrW-1:0]   addr;
        logic [SampleW-1:0] data;
        logic [TrimW-1:0]   trim;
        logic               last;
    } t_result;

    typedef struct packed {
        t_kind              first_kind;
        logic [AddrW-1:0]   first_addr;
        logic [SampleW-1:0] first_data;
        logic               has_marker;
        logic               marker_right;
        logic               has_trim;
    } t_stage;

    typedef struct packed {
        logic [1:0]                 cnt;
        t_result [MaxResults-1:0]   entry;
    } t_push;

endpackage

// File: design/arwt_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwt_result_fifo
// Result queue taking up to three entries per cycle and giving one per cycle
// ----------------------------------------------------------------------------
module arwt_result_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  arwt_pkg::t_push               i_push,
    input  logic                          i_pop,
    output arwt_pkg::t_result             o_head,
    output logic [arwt_pkg::FifoCntW-1:0] o_count
);

    arwt_pkg::t_result                r_mem [arwt_pkg::FifoDepth];
    logic [arwt_pkg::FifoPtrW-1:0]    r_wr_ptr;
    logic [arwt_pkg::FifoPtrW-1:0]    r_rd_ptr;
    logic [arwt_pkg::FifoCntW-1:0]    r_count;
    logic [arwt_pkg::FifoCntW-1:0]    n_count;

    always_comb begin
        n_count = r_count + arwt_pkg::FifoCntW'(i_push.cnt)
                  - arwt_pkg::FifoCntW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < arwt_pkg::MaxResults; i++) begin
            if (2'(i) < i_push.cnt) begin
                r_mem[r_wr_ptr + arwt_pkg::FifoPtrW'(i)] <= i_push.entry[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + arwt_pkg::FifoPtrW'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + arwt_pkg::FifoPtrW'(i_pop);
            r_count  <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: design/audio_ring_writer_with_pi_clock_trim_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_ring_writer_with_pi_clock_trim_core
// Ring buffer write command generator with PI oscillator trim loop
// ----------------------------------------------------------------------------
// s_axis carries audio samples (tuser 0) and frame ticks (tuser 1); tlast
// marks the last sample of a USB packet, tdata holds the sample and the DMA
// remaining count. m_axis gives buffer writes, clear requests and trim
// updates (kind in tuser); tlast marks the final result caused by one input.
// The cfg channel writes the six control registers and is always ready;
// write it only while the block is idle.
// Each input transfer gives zero to three results. The first result of an
// item passes the state update register, then the gain multiply and the
// sum registers, then the divide by 1000 as it enters the 16-entry result
// queue. One item is taken per cycle while the queue has room for everything
// in flight; the queue drains one result per cycle while m_axis is ready, so
// items with several results run at that drain rate.
// A stall on m_axis fills the queue and then deasserts s_axis_tready.
// Reset empties the queue and pipeline, restores register defaults, and puts
// the write pointer half a ring plus one ahead.
// ----------------------------------------------------------------------------
module audio_ring_writer_with_pi_clock_trim_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // cfg
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [arwt_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [arwt_pkg::CfgDataW-1:0]  i_cfg_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [arwt_pkg::InDataW-1:0]   s_axis_tdata,  // sample_value[15:0], dma_remaining[25:16]
    input  logic [0:0]                     s_axis_tuser,  // opcode[0]
    input  logic                           s_axis_tlast,
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [arwt_pkg::OutDataW-1:0]  m_axis_tdata,  // write_address[8:0], write_data[24:9], trim_value[30:25]
    output logic [arwt_pkg::KindW-1:0]     m_axis_tuser,  // result_kind[1:0]
    output logic                           m_axis_tlast
);

    localparam int AW = arwt_pkg::AddrW;
    localparam int IW = arwt_pkg::IntegW;
    localparam int EW = arwt_pkg::ErrW;

    // configuration registers
    logic                           r_cfg_enable;
    logic [arwt_pkg::CenterW-1:0]   r_cfg_center;
    logic [arwt_pkg::GainW-1:0]     r_cfg_prop;
    logic [arwt_pkg::GainW-1:0]     r_cfg_igain;
    logic [arwt_pkg::LimitW-1:0]    r_cfg_limit;
    logic [arwt_pkg::HoldW-1:0]     r_cfg_hold;

    // loop state
    logic [AW-1:0]                  r_wp, n_wp;
    logic [arwt_pkg::HoldW-1:0]     r_hold, n_hold;
    logic signed [IW-1:0]           r_integ, n_integ;
    logic                           r_packet_open, n_packet_open;
    logic                           r_index_odd, n_index_odd;
    logic                           r_right_act, n_right_act;
    logic                           r_left_act, n_left_act;

    // pipeline
    logic                           r1_valid, n1_valid;
    arwt_pkg::t_stage               r1_stage, n1_stage;
    logic signed [EW-1:0]           r1_err, n1_err;
    logic signed [IW-1:0]           r1_integ;
    logic                           r2_valid;
    arwt_pkg::t_stage               r2_stage;
    logic signed [arwt_pkg::PropProdW-1:0] r2_p_prop;
    logic signed [arwt_pkg::NumW-1:0]      r2_p_int;
    logic                           r3_valid;
    arwt_pkg::t_stage               r3_stage;
    logic signed [arwt_pkg::NumW-1:0]      r3_num;

    // input fields
    arwt_pkg::t_opcode              in_op;
    logic [arwt_pkg::SampleW-1:0]   in_sample;
    logic [arwt_pkg::DmaW-1:0]      in_dma;
    logic                           in_accept;
    logic [AW-1:0]                  rd_slot;

    // per-item working values
    logic                           start;
    logic                           idx;
    logic                           ra;
    logic                           la;
    logic [AW-1:0]                  wp;
    logic [AW-1:0]                  wp_next;
    logic [AW-1:0]                  resync;
    logic [AW-1:0]                  measure;
    logic signed [IW-1:0]           integ;
    logic signed [IW:0]             integ_sum;
    logic signed [IW:0]             lim;

    // queue side
    logic [arwt_pkg::FifoCntW-1:0]  q_count;
    logic [arwt_pkg::FifoCntW:0]    reserve;
    arwt_pkg::t_push                push;
    arwt_pkg::t_result              head;
    arwt_pkg::t_result              res_first;
    arwt_pkg::t_result              res_marker;
    arwt_pkg::t_result              res_trim;
    logic [arwt_pkg::TrimW-1:0]     trim;
    logic [32:0]                    recip_prod;
    logic [15:0]                    center_k;
    logic                           pop;

    // ------------------------------------------------------------------
    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable <= 1'b0;
            r_cfg_center <= arwt_pkg::CenterW'(32);
            r_cfg_prop   <= arwt_pkg::GainW'(5);
            r_cfg_igain  <= arwt_pkg::GainW'(1);
            r_cfg_limit  <= arwt_pkg::LimitW'(50000);
            r_cfg_hold   <= arwt_pkg::HoldW'(10);
        end else if (i_cfg_valid) begin
            case (arwt_pkg::t_cfg_reg'(i_cfg_index))
                arwt_pkg::CFG_AUDIO_ENABLE: r_cfg_enable <= i_cfg_data[0];
                arwt_pkg::CFG_TRIM_CENTER:  r_cfg_center <= i_cfg_data[arwt_pkg::CenterW-1:0];
                arwt_pkg::CFG_PROP_GAIN:    r_cfg_prop   <= i_cfg_data[arwt_pkg::GainW-1:0];
                arwt_pkg::CFG_INTEG_GAIN:   r_cfg_igain  <= i_cfg_data[arwt_pkg::GainW-1:0];
                arwt_pkg::CFG_INTEG_LIMIT:  r_cfg_limit  <= i_cfg_data[arwt_pkg::LimitW-1:0];
                arwt_pkg::CFG_HOLD_PACKETS: r_cfg_hold   <= i_cfg_data[arwt_pkg::HoldW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input decode and flow control
    assign in_op     = arwt_pkg::t_opcode'(s_axis_tuser[0]);
    assign in_sample = s_axis_tdata[arwt_pkg::SampleW-1:0];
    assign in_dma    = s_axis_tdata[arwt_pkg::SampleW +: arwt_pkg::DmaW];

    always_comb begin
        if (in_dma != '0 && in_dma <= arwt_pkg::RingSize) begin
            rd_slot = AW'(arwt_pkg::RingSize - in_dma);
        end else begin
            rd_slot = '0;
        end
    end

    // room for the results of every item in flight plus the new one
    assign reserve = (arwt_pkg::FifoCntW + 1)'(arwt_pkg::MaxResults)
                     * ((arwt_pkg::FifoCntW + 1)'(r1_valid)
                        + (arwt_pkg::FifoCntW + 1)'(r2_valid)
                        + (arwt_pkg::FifoCntW + 1)'(r3_valid) + 1'b1);
    assign s_axis_tready = ((arwt_pkg::FifoCntW + 1)'(q_count) + reserve)
                           <= (arwt_pkg::FifoCntW + 1)'(arwt_pkg::FifoDepth);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // state update
    always_comb begin
        n_wp          = r_wp;
        n_hold        = r_hold;
        n_integ       = r_integ;
        n_packet_open = r_packet_open;
        n_index_odd   = r_index_odd;
        n_right_act   = r_right_act;
        n_left_act    = r_left_act;
        n1_valid      = 1'b0;
        n1_stage      = '0;
        n1_err        = '0;
        start         = !r_packet_open;
        idx           = r_index_odd;
        ra            = r_right_act;
        la            = r_left_act;
        wp            = r_wp;
        integ         = r_integ;
        resync        = rd_slot + arwt_pkg::HalfRing;
        wp_next       = r_wp;
        measure       = '0;
        integ_sum     = '0;
        lim           = $signed({2'b00, r_cfg_limit});

        if (in_accept) begin
            if (in_op == arwt_pkg::OP_TICK) begin
                if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                end
            end else if (!r_cfg_enable) begin
                if (!r_packet_open) begin
                    n1_valid            = 1'b1;
                    n1_stage.first_kind = arwt_pkg::KIND_CLEAR;
                end
                n_packet_open = !s_axis_tlast;
                n_index_odd   = 1'b0;
                n_right_act   = 1'b0;
                n_left_act    = 1'b0;
            end else begin
                if (start) begin
                    idx = 1'b0;
                    ra  = 1'b0;
                    la  = 1'b0;
                    if (r_hold == '0) begin
                        wp    = {resync[AW-1:1], 1'b1};
                        integ = '0;
                    end
                end
                n1_valid            = 1'b1;
                n1_stage.first_kind = arwt_pkg::KIND_WRITE;
                n1_stage.first_addr = wp;
                n1_stage.first_data = in_sample;
                wp_next = wp + 1'b1;
                if (in_sample != '0) begin
                    if (idx) begin
                        la = 1'b1;
                    end else begin
                        ra = 1'b1;
                    end
                end
                idx = !idx;
                if (s_axis_tlast) begin
                    n1_stage.has_marker   = ra ^ la;
                    n1_stage.marker_right = ra;
                    if (ra || la) begin
                        n_hold            = r_cfg_hold;
                        n1_stage.has_trim = 1'b1;
                        measure   = wp_next - rd_slot;
                        n1_err    = $signed(EW'(measure) - EW'(arwt_pkg::HalfRing));
                        integ_sum = {integ[IW-1], integ} + {{(IW + 1 - EW){n1_err[EW-1]}}, n1_err};
                        if (integ_sum > lim) begin
                            integ_sum = lim;
                        end else if (integ_sum < -lim) begin
                            integ_sum = -lim;
                        end
                        integ = integ_sum[IW-1:0];
                    end
                end
                n_wp          = wp_next;
                n_integ       = integ;
                n_index_odd   = idx;
                n_right_act   = ra;
                n_left_act    = la;
                n_packet_open = !s_axis_tlast;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp          <= arwt_pkg::HalfRing + 1'b1;
            r_hold        <= '0;
            r_integ       <= '0;
            r_packet_open <= 1'b0;
            r_index_odd   <= 1'b0;
            r_right_act   <= 1'b0;
            r_left_act    <= 1'b0;
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
        end else begin
            r_wp          <= n_wp;
            r_hold        <= n_hold;
            r_integ       <= n_integ;
            r_packet_open <= n_packet_open;
            r_index_odd   <= n_index_odd;
            r_right_act   <= n_right_act;
            r_left_act    <= n_left_act;
            r1_valid      <= n1_valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
        end
    end

    // ------------------------------------------------------------------
    // PI arithmetic pipeline
    assign center_k = 16'(r_cfg_center) * arwt_pkg::Milli;

    always_ff @(posedge i_clk) begin
        r1_stage  <= n1_stage;
        r1_err    <= n1_err;
        r1_integ  <= n_integ;
        r2_stage  <= r1_stage;
        r2_p_prop <= $signed({1'b0, r_cfg_prop}) * r1_err;
        r2_p_int  <= arwt_pkg::NumW'($signed({1'b0, r_cfg_igain}))
                     * arwt_pkg::NumW'(r1_integ);
        r3_stage  <= r2_stage;
        r3_num    <= {{(arwt_pkg::NumW - arwt_pkg::PropProdW){r2_p_prop[arwt_pkg::PropProdW-1]}},
                      r2_p_prop}
                     + r2_p_int + $signed({16'b0, center_k});
    end

    // divide by 1000 and clamp to the trim range
    assign recip_prod = 33'(r3_num[15:0]) * 33'(arwt_pkg::Recip1000);

    always_comb begin
        if (r3_num <= 0) begin
            trim = '0;
        end else if (r3_num >= $signed(arwt_pkg::TrimSatNum)) begin
            trim = arwt_pkg::TrimMax;
        end else begin
            trim = recip_prod[arwt_pkg::RecipShift +: arwt_pkg::TrimW];
        end
    end

    // ------------------------------------------------------------------
    // result assembly
    always_comb begin
        res_first.kind   = r3_stage.first_kind;
        res_first.addr   = r3_stage.first_addr;
        res_first.data   = r3_stage.first_data;
        res_first.trim   = '0;
        res_first.last   = !(r3_stage.has_marker || r3_stage.has_trim);

        res_marker.kind  = arwt_pkg::KIND_WRITE;
        res_marker.addr  = AW'(r3_stage.marker_right);
        res_marker.data  = arwt_pkg::SampleW'(1);
        res_marker.trim  = '0;
        res_marker.last  = !r3_stage.has_trim;

        res_trim.kind    = arwt_pkg::KIND_TRIM;
        res_trim.addr    = '0;
        res_trim.data    = '0;
        res_trim.trim    = trim;
        res_trim.last    = 1'b1;

        push.entry[0] = res_first;
        push.entry[1] = r3_stage.has_marker ? res_marker : res_trim;
        push.entry[2] = res_trim;
        if (r3_valid) begin
            push.cnt = 2'd1 + 2'(r3_stage.has_marker) + 2'(r3_stage.has_trim);
        end else begin
            push.cnt = '0;
        end
    end

    assign pop = m_axis_tvalid && m_axis_tready;

    arwt_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    assign m_axis_tvalid = (q_count != '0);
    assign m_axis_tdata  = {1'b0, head.trim, head.data, head.addr};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio ring writer with PI trim loop
// ----------------------------------------------------------------------------
// Drives samples and frame ticks into the block and tracks its pointer, hold
// count and integral in a scoreboard to predict every buffer write, clear
// request and trim update. A short directed part covers disabled packets,
// channel markers, silent packets, hold-count saturation and enable toggled
// mid-packet. Random USB-like packet traffic follows under several register
// settings and idle patterns on both streams, including one long sink
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    import arwt_pkg::*;

    localparam int CycleLimit = 300000;

    class trim_scoreboard;
        bit                  enable;
        bit [CenterW-1:0]    center;
        bit [GainW-1:0]      kp;
        bit [GainW-1:0]      ki;
        bit [LimitW-1:0]     ilim;
        bit [HoldW-1:0]      hold_reload;
        bit [AddrW-1:0]      wr_ptr;
        bit [HoldW-1:0]      hold_left;
        longint              integ;
        bit                  pkt_open;
        bit                  odd_idx;
        bit                  right_on;
        bit                  left_on;
        t_result             due_results[$];
        int                  errors;

        function new();
            enable      = 1'b0;
            center      = 6'd32;
            kp          = 10'd5;
            ki          = 10'd1;
            ilim        = 20'd50000;
            hold_reload = 8'd10;
            wr_ptr      = AddrW'(RingSamples / 2 + 1);
            hold_left   = '0;
            integ       = 0;
            pkt_open    = 1'b0;
            odd_idx     = 1'b0;
            right_on    = 1'b0;
            left_on     = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(t_cfg_reg r, bit [CfgDataW-1:0] v);
            case (r)
                CFG_AUDIO_ENABLE: enable = v[0];
                CFG_TRIM_CENTER:  center = v[CenterW-1:0];
                CFG_PROP_GAIN:    kp = v[GainW-1:0];
                CFG_INTEG_GAIN:   ki = v[GainW-1:0];
                CFG_INTEG_LIMIT:  ilim = v[LimitW-1:0];
                CFG_HOLD_PACKETS: hold_reload = v[HoldW-1:0];
                default: ;
            endcase
        endfunction

        function void push(t_kind k, bit [AddrW-1:0] a, bit [SampleW-1:0] d,
                           bit [TrimW-1:0] t);
            t_result r;
            r.kind = k;
            r.addr = a;
            r.data = d;
            r.trim = t;
            r.last = 1'b0;
            due_results.push_back(r);
        endfunction

        function bit [TrimW-1:0] trim_step(int rd);
            int     measure;
            int     err;
            longint lim;
            longint num;
            lim = longint'(ilim);
            measure = int'(wr_ptr) - rd;
            if (measure < 0)
                measure += RingSamples;
            err = measure - RingSamples / 2;
            integ += err;
            if (integ > lim)
                integ = lim;
            else if (integ < -lim)
                integ = -lim;
            num = longint'(kp) * err + longint'(ki) * integ + 1000 * longint'(center);
            if (num <= 0)
                return '0;
            num = num / 1000;
            return (num > 63) ? TrimMax : TrimW'(num);
        endfunction

        function void note_input(t_opcode op, bit [SampleW-1:0] smp, bit pkt_end,
                                 bit [DmaW-1:0] dma);
            int rd;
            int p;
            int n0;
            n0 = due_results.size();
            rd = (dma == 0 || dma > RingSamples) ? 0 : RingSamples - int'(dma);
            if (op == OP_TICK) begin
                if (hold_left > 0)
                    hold_left--;
                return;
            end
            if (!enable) begin
                if (!pkt_open)
                    push(KIND_CLEAR, '0, '0, '0);
                pkt_open = !pkt_end;
                odd_idx  = 1'b0;
                right_on = 1'b0;
                left_on  = 1'b0;
            end else begin
                if (!pkt_open) begin
                    odd_idx  = 1'b0;
                    right_on = 1'b0;
                    left_on  = 1'b0;
                    if (hold_left == 0) begin
                        p = rd + RingSamples / 2;
                        if (p % 2 == 0)
                            p++;
                        wr_ptr = AddrW'(p % RingSamples);
                        integ = 0;
                    end
                end
                push(KIND_WRITE, wr_ptr, smp, '0);
                wr_ptr = wr_ptr + 1'b1;
                if (smp != 0) begin
                    if (odd_idx)
                        left_on = 1'b1;
                    else
                        right_on = 1'b1;
                end
                odd_idx = !odd_idx;
                if (pkt_end) begin
                    if (right_on && !left_on)
                        push(KIND_WRITE, AddrW'(1), SampleW'(1), '0);
                    else if (left_on && !right_on)
                        push(KIND_WRITE, AddrW'(0), SampleW'(1), '0);
                    if (right_on || left_on) begin
                        hold_left = hold_reload;
                        push(KIND_TRIM, '0, '0, trim_step(rd));
                    end
                end
                pkt_open = !pkt_end;
            end
            if (due_results.size() > n0)
                due_results[due_results.size() - 1].last = 1'b1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [KindW-1:0] k, logic [AddrW-1:0] a,
                          logic [SampleW-1:0] d, logic [TrimW-1:0] t, logic l);
            t_result e;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d addr %0d data %h trim %0d",
                                 k, a, d, t));
                return;
            end
            e = due_results.pop_front();
            if (k !== e.kind || a !== e.addr || d !== e.data || t !== e.trim
                    || l !== e.last)
                report($sformatf("got kind %0d addr %0d data %h trim %0d last %b, want %0d %0d %h %0d %b",
                                 k, a, d, t, l, e.kind, e.addr, e.data, e.trim, e.last));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CfgIdxW-1:0]     i_cfg_index;
    logic [CfgDataW-1:0]    i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [InDataW-1:0]     s_axis_tdata;   // sample_value[15:0], dma_remaining[25:16]
    logic [0:0]             s_axis_tuser;   // opcode[0]
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OutDataW-1:0]    m_axis_tdata;   // write_address[8:0], write_data[24:9], trim_value[30:25]
    logic [KindW-1:0]       m_axis_tuser;   // result_kind[1:0]
    logic                   m_axis_tlast;

    trim_scoreboard sb;
    int             src_idle_pct;
    int             sink_stall_pct;
    int             sink_hold_cycles;
    int             cycles;

    audio_ring_writer_with_pi_clock_trim_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sink side: long hold-off first, else random stalls
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                sink_hold_cycles--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[8:0], m_axis_tdata[24:9],
                            m_axis_tdata[30:25], m_axis_tlast);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // called and returns at a falling edge
    task send_item(t_opcode op, logic [SampleW-1:0] smp, logic pkt_end,
                   logic [DmaW-1:0] dma);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tlast  = pkt_end;
        s_axis_tdata  = {6'd0, dma, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, smp, pkt_end, dma);
        @(negedge i_clk);
    endtask

    task send_tick();
        send_item(OP_TICK, SampleW'($urandom), 1'($urandom), DmaW'($urandom_range(512)));
    endtask

    task write_reg(t_cfg_reg r, logic [CfgDataW-1:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_index = r;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(r, v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task wait_settle();
        s_axis_tvalid = 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task write_all(bit en, int ctr, int p_gain, int i_gain, int lim, int hold);
        write_reg(CFG_AUDIO_ENABLE, CfgDataW'(en));
        write_reg(CFG_TRIM_CENTER, CfgDataW'(ctr));
        write_reg(CFG_PROP_GAIN, CfgDataW'(p_gain));
        write_reg(CFG_INTEG_GAIN, CfgDataW'(i_gain));
        write_reg(CFG_INTEG_LIMIT, CfgDataW'(lim));
        write_reg(CFG_HOLD_PACKETS, CfgDataW'(hold));
    endtask

    function logic [DmaW-1:0] pick_dma();
        case ($urandom_range(9))
            0: return DmaW'(0);
            1: return DmaW'(512);
            2: return DmaW'(1);
            default: return DmaW'($urandom_range(1, 511));
        endcase
    endfunction

    function logic [SampleW-1:0] pick_sample(int mode, int idx);
        logic [SampleW-1:0] v;
        case ($urandom_range(9))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            default: v = SampleW'($urandom);
        endcase
        if (v == 0)
            v = 16'h0001;
        case (mode)
            0: return '0;
            1: return (idx % 2 == 0) ? v : '0;
            2: return (idx % 2 == 1) ? v : '0;
            default: return ($urandom_range(7) == 0) ? '0 : v;
        endcase
    endfunction

    // mostly whole packets, some tick bursts, a little loose noise
    task random_traffic(int n_items);
        int sent;
        int len;
        int mode;
        int sel;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                len  = $urandom_range(1, 8);
                mode = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    send_item(OP_SAMPLE, pick_sample(mode, i), i == len - 1, pick_dma());
                    sent++;
                end
            end else if (sel < 88) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    send_tick();
                    sent++;
                end
            end else begin
                send_item(OP_SAMPLE, SampleW'($urandom), 1'($urandom), pick_dma());
                sent++;
            end
        end
    endtask

    initial begin
        sb               = new();
        cycles           = 0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 0;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = '0;
        s_axis_tlast     = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // disabled: clear on packet start only
        send_item(OP_SAMPLE, 16'h8000, 1'b0, 10'd0);
        send_item(OP_SAMPLE, 16'h7fff, 1'b1, 10'd512);
        wait_settle();
        write_reg(CFG_AUDIO_ENABLE, CfgDataW'(1));
        write_reg(CFG_HOLD_PACKETS, CfgDataW'(2));

        // resync then both channels active
        send_item(OP_SAMPLE, 16'h7fff, 1'b0, 10'd512);
        send_item(OP_SAMPLE, 16'h8000, 1'b0, 10'd1);
        send_item(OP_SAMPLE, 16'hffff, 1'b0, 10'd511);
        send_item(OP_SAMPLE, 16'h0001, 1'b1, 10'd256);
        // right only, left only, silent
        send_item(OP_SAMPLE, 16'h1234, 1'b0, 10'd100);
        send_item(OP_SAMPLE, 16'h0000, 1'b1, 10'd100);
        send_item(OP_SAMPLE, 16'h0000, 1'b0, 10'd300);
        send_item(OP_SAMPLE, 16'habcd, 1'b1, 10'd300);
        send_item(OP_SAMPLE, 16'h0000, 1'b0, 10'd7);
        send_item(OP_SAMPLE, 16'h0000, 1'b1, 10'd7);
        // hold count runs out and saturates
        send_tick();
        send_tick();
        send_tick();
        send_item(OP_SAMPLE, 16'h5555, 1'b1, 10'd200);
        // enable dropped and raised inside packets
        send_item(OP_SAMPLE, 16'haaaa, 1'b0, 10'd50);
        wait_settle();
        write_reg(CFG_AUDIO_ENABLE, CfgDataW'(0));
        send_item(OP_SAMPLE, 16'h0102, 1'b0, 10'd50);
        send_item(OP_SAMPLE, 16'h0000, 1'b1, 10'd50);
        send_item(OP_SAMPLE, 16'hfffe, 1'b0, 10'd50);
        wait_settle();
        write_reg(CFG_AUDIO_ENABLE, CfgDataW'(1));
        send_item(OP_SAMPLE, 16'hc000, 1'b1, 10'd60);
        wait_settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_all(1'b1, 32, 1000, 1000, 1000000, 255);
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    sink_hold_cycles = 300;
                end
                1: begin
                    write_all(1'b1, 0, 0, 0, 0, 0);
                    src_idle_pct = 87;
                    sink_stall_pct = 0;
                end
                2: begin
                    write_all(1'b1, 63, 1000, 0, 1, 1);
                    src_idle_pct = 0;
                    sink_stall_pct = 87;
                end
                3: begin
                    write_all(1'b1, $urandom_range(63), $urandom_range(1000),
                              $urandom_range(1000), $urandom_range(1000000),
                              $urandom_range(255));
                    src_idle_pct = 38;
                    sink_stall_pct = 38;
                end
                default: begin
                    write_all(1'b0, 5, 3, 2, 100, 4);
                    src_idle_pct = 38;
                    sink_stall_pct = 38;
                end
            endcase
            random_traffic((ph == 4) ? 10 : 32);
            wait_settle();
        end

        sink_stall_pct = 0;
        wait_settle();
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
